// ===== hw/rtl/ipsc_pkg.sv =====
// ----------------------------------------------------------------------------
// ipsc_pkg
// Shared types, codes and reset values of the inactivity power state controller
// ----------------------------------------------------------------------------
`default_nettype none

package ipsc_pkg;

	localparam int TIMER_WIDTH_DEF = 24;
	localparam int CFG_DATA_W      = 24;
	localparam int CFG_INDEX_W     = 3;
	localparam int TIMEOUT_W       = 24;
	localparam int MV_W            = 13;
	localparam int BATT_W          = 16;
	localparam int IDLE_OUT_W      = 24;
	localparam int IN_TDATA_W      = 16;
	localparam int OUT_TDATA_W     = 32;

	// configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DIM_TIMEOUT   = 3'd0,
		REG_LIGHT_TIMEOUT = 3'd1,
		REG_DEEP_TIMEOUT  = 3'd2,
		REG_SHUTDOWN_MV   = 3'd3,
		REG_BATT_PERIOD   = 3'd4,
		REG_PMU_PRESENT   = 3'd5
	} reg_index_t;

	// event kinds
	typedef enum logic [2:0] {
		KIND_TICK        = 3'd0,
		KIND_ACTIVITY    = 3'd1,
		KIND_WAKE_DONE   = 3'd2,
		KIND_FORCE_ACT   = 3'd3,
		KIND_FORCE_LIGHT = 3'd4
	} kind_t;

	// power state, one-hot
	typedef enum logic [3:0] {
		MODE_ACTIVE = 4'b0001,
		MODE_DIMMED = 4'b0010,
		MODE_LIGHT  = 4'b0100,
		MODE_DEEP   = 4'b1000
	} mode_t;

	localparam logic [1:0] CODE_ACTIVE = 2'd0;
	localparam logic [1:0] CODE_DIMMED = 2'd1;
	localparam logic [1:0] CODE_LIGHT  = 2'd2;
	localparam logic [1:0] CODE_DEEP   = 2'd3;

	localparam logic [TIMEOUT_W-1:0] DIM_TIMEOUT_RST   = 24'd15000;
	localparam logic [TIMEOUT_W-1:0] LIGHT_TIMEOUT_RST = 24'd30000;
	localparam logic [TIMEOUT_W-1:0] DEEP_TIMEOUT_RST  = 24'd300000;
	localparam logic [MV_W-1:0]      SHUTDOWN_MV_RST   = 13'd3300;
	localparam logic [BATT_W-1:0]    BATT_PERIOD_RST   = 16'd10000;
	localparam logic                 PMU_PRESENT_RST   = 1'b1;

	function automatic logic [1:0] mode_code(input mode_t m);
		logic [1:0] c;
		unique case (m)
			MODE_ACTIVE: c = CODE_ACTIVE;
			MODE_DIMMED: c = CODE_DIMMED;
			MODE_LIGHT:  c = CODE_LIGHT;
			MODE_DEEP:   c = CODE_DEEP;
			default:     c = CODE_ACTIVE;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/inactivity_power_state_controller.sv =====
// ----------------------------------------------------------------------------
// inactivity_power_state_controller
// Power state machine driven by millisecond ticks and user events, with idle
// timeouts, light/deep sleep and a periodic low-battery check.
// Each request passes the input register, then the state update and result
// register. Throughput: one request per cycle unless m_tready stalls the
// result stream; the state update is one pass of compares and saturating
// increments, so requests follow back to back.
// Reset: arst_n clears the state to active with all counters and flags at
// zero and loads the configuration registers with their default values.
// ----------------------------------------------------------------------------
`default_nettype none

module inactivity_power_state_controller #(
	parameter int TIMER_WIDTH = ipsc_pkg::TIMER_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration write port
	input  wire logic                              cfg_wr_en,
	input  wire logic [ipsc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [ipsc_pkg::CFG_DATA_W-1:0]   cfg_data,
	// input stream
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// recording, charging, battery_mv, zero pad
	input  wire logic [ipsc_pkg::IN_TDATA_W-1:0]   s_tdata,
	// kind
	input  wire logic [2:0]                        s_tuser,
	// result stream
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// power_mode, wake_pending, cpu_lock_held, shutdown_request,
	// deep_sleep_request, radio_sleep_request, idle_time_ms, zero pad
	output logic [ipsc_pkg::OUT_TDATA_W-1:0]       m_tdata
);

	import ipsc_pkg::*;

	localparam int TW = TIMER_WIDTH;
	localparam int CW = (TW > TIMEOUT_W) ? TW : TIMEOUT_W;

	function automatic logic [TW-1:0] sat_inc(input logic [TW-1:0] v);
		return (v == {TW{1'b1}}) ? v : v + 1'b1;
	endfunction

	// configuration registers
	logic [TIMEOUT_W-1:0] cfg_dim_q, cfg_light_q, cfg_deep_q;
	logic [MV_W-1:0]      cfg_thresh_q;
	logic [BATT_W-1:0]    cfg_period_q;
	logic                 cfg_pmu_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_dim_q    <= DIM_TIMEOUT_RST;
			cfg_light_q  <= LIGHT_TIMEOUT_RST;
			cfg_deep_q   <= DEEP_TIMEOUT_RST;
			cfg_thresh_q <= SHUTDOWN_MV_RST;
			cfg_period_q <= BATT_PERIOD_RST;
			cfg_pmu_q    <= PMU_PRESENT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_DIM_TIMEOUT:   cfg_dim_q    <= cfg_data[TIMEOUT_W-1:0];
				REG_LIGHT_TIMEOUT: cfg_light_q  <= cfg_data[TIMEOUT_W-1:0];
				REG_DEEP_TIMEOUT:  cfg_deep_q   <= cfg_data[TIMEOUT_W-1:0];
				REG_SHUTDOWN_MV:   cfg_thresh_q <= cfg_data[MV_W-1:0];
				REG_BATT_PERIOD:   cfg_period_q <= cfg_data[BATT_W-1:0];
				REG_PMU_PRESENT:   cfg_pmu_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// pipeline control
	logic s1_valid_q, out_valid_s2, advance;
	logic [2:0]      kind_s1;
	logic            rec_s1, chg_s1;
	logic [MV_W-1:0] mv_s1;

	assign advance  = !out_valid_s2 || m_tready;
	assign s_tready = !s1_valid_q || advance;
	assign m_tvalid = out_valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q   <= 1'b0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				s1_valid_q <= s_tvalid;
			if (advance)
				out_valid_s2 <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1 <= s_tuser;
			rec_s1  <= s_tdata[0];
			chg_s1  <= s_tdata[1];
			mv_s1   <= s_tdata[MV_W+1:2];
		end
	end

	// controller state
	mode_t             mode_q, mode_d;
	logic [TW-1:0]     idle_q, idle_d, sleep_q, sleep_d;
	logic [BATT_W-1:0] batt_q, batt_d, batt_inc;
	logic              wake_q, wake_d, lock_q, lock_d;
	logic              shut, deep_req, radio_req;

	assign batt_inc = (batt_q == {BATT_W{1'b1}}) ? batt_q : batt_q + 1'b1;

	always_comb begin
		mode_d    = mode_q;
		idle_d    = idle_q;
		sleep_d   = sleep_q;
		batt_d    = batt_q;
		wake_d    = wake_q;
		lock_d    = lock_q;
		shut      = 1'b0;
		deep_req  = 1'b0;
		radio_req = 1'b0;
		if (mode_q != MODE_DEEP) begin
			unique case (kind_s1)
				KIND_TICK: begin
					idle_d = sat_inc(idle_q);
					if (mode_q == MODE_LIGHT)
						sleep_d = sat_inc(sleep_q);
					batt_d = batt_inc;
					if (batt_inc > cfg_period_q) begin
						batt_d = '0;
						if (cfg_pmu_q && (mv_s1 < cfg_thresh_q) && !chg_s1)
							shut = 1'b1;
					end
					if (rec_s1) begin
						if (mode_q != MODE_ACTIVE) begin
							mode_d = MODE_ACTIVE;
							lock_d = 1'b1;
						end
					end else begin
						lock_d = 1'b0;
						unique case (mode_q)
							MODE_ACTIVE: begin
								if (CW'(idle_d) >= CW'(cfg_dim_q))
									mode_d = MODE_DIMMED;
							end
							MODE_DIMMED: begin
								if (CW'(idle_d) >= CW'(cfg_light_q)) begin
									mode_d    = MODE_LIGHT;
									sleep_d   = '0;
									radio_req = 1'b1;
								end
							end
							MODE_LIGHT: begin
								if ((cfg_deep_q != '0) && (CW'(sleep_d) >= CW'(cfg_deep_q))) begin
									mode_d   = MODE_DEEP;
									deep_req = 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
				KIND_ACTIVITY: begin
					idle_d = '0;
					if (mode_q == MODE_LIGHT) begin
						wake_d = 1'b1;
					end else if (mode_q == MODE_DIMMED) begin
						mode_d  = MODE_ACTIVE;
						sleep_d = '0;
					end
				end
				KIND_WAKE_DONE: begin
					mode_d  = MODE_ACTIVE;
					idle_d  = '0;
					sleep_d = '0;
					wake_d  = 1'b0;
					lock_d  = 1'b0;
				end
				KIND_FORCE_ACT: begin
					mode_d = MODE_ACTIVE;
					idle_d = '0;
				end
				KIND_FORCE_LIGHT: begin
					if (!rec_s1) begin
						mode_d  = MODE_LIGHT;
						sleep_d = '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_ACTIVE;
			idle_q  <= '0;
			sleep_q <= '0;
			batt_q  <= '0;
			wake_q  <= 1'b0;
			lock_q  <= 1'b0;
		end else if (advance && s1_valid_q) begin
			mode_q  <= mode_d;
			idle_q  <= idle_d;
			sleep_q <= sleep_d;
			batt_q  <= batt_d;
			wake_q  <= wake_d;
			lock_q  <= lock_d;
		end
	end

	// result register
	logic [OUT_TDATA_W-1:0] m_tdata_s2;

	always_ff @(posedge clk) begin
		if (advance && s1_valid_q) begin
			m_tdata_s2 <= {1'b0, IDLE_OUT_W'(idle_d), radio_req, deep_req, shut,
				lock_d, wake_d, mode_code(mode_d)};
		end
	end

	assign m_tdata = m_tdata_s2;

	// deep sleep holds until reset
	a_deep_terminal: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_DEEP |=> mode_q == MODE_DEEP)
		else $error("deep sleep left without reset");

	a_deep_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[5]) |-> m_tdata[1:0] == CODE_DEEP)
		else $error("deep sleep request without deep sleep state");

	a_radio_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[6]) |-> m_tdata[1:0] == CODE_LIGHT)
		else $error("radio sleep request without light sleep state");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (s1_valid_q && out_valid_s2 && !m_tready))
		else $error("input stalled while pipeline can move");

endmodule

`default_nettype wire
